>>> rtl/min_edge_reversal_path_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MIN_EDGE_REVERSAL_PATH_CORE_DEFINES_SVH
`define MIN_EDGE_REVERSAL_PATH_CORE_DEFINES_SVH

// Implication in the same cycle, ignored during reset.
`define MERP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, ignored during reset.
`define MERP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, checked across reset as well.
`define MERP_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/min_erp_pkg.sv
// Types and constants of the minimum edge reversal path block.
package min_erp_pkg;

    localparam int NODE_W    = 8;
    localparam int MAX_NODES = 256;
    localparam int DIST_W    = NODE_W + 1;   // reached flag + distance
    localparam int RES_W     = 1 + NODE_W;   // ok + reversals

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_QUERY,
        OP_CLEAR,
        OP_REJECT
    } t_op;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_INIT,
        BS_PASS,
        BS_EDGE_RD,
        BS_DIST_RD,
        BS_RELAX,
        BS_FIN_RD,
        BS_FIN
    } t_bstate;

endpackage

>>> rtl/min_erp_fifo.sv
// Small synchronous FIFO used for the job queue and the result queue.
module min_erp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

>>> rtl/min_erp_front.sv
// Front end: range checks, store fill tracking and job encoding.
module min_erp_front #(
    parameter int MAX_EDGES = 1024,
    parameter int EW        = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_command,
    input  logic [min_erp_pkg::NODE_W-1:0] i_first_node,
    input  logic [min_erp_pkg::NODE_W-1:0] i_second_node,
    input  logic [min_erp_pkg::NODE_W-1:0] i_top,
    output logic [2+2*min_erp_pkg::NODE_W+EW-1:0] o_job
);
    logic [EW-1:0] r_edge_cnt, n_edge_cnt;
    min_erp_pkg::t_op op;
    logic            out_of_range;

    assign out_of_range = (i_first_node > i_top) || (i_second_node > i_top);

    always_comb begin
        n_edge_cnt = r_edge_cnt;
        op         = min_erp_pkg::OP_REJECT;
        unique case (i_command)
            min_erp_pkg::CMD_ADD: begin
                if (!out_of_range && (r_edge_cnt != EW'(MAX_EDGES))) begin
                    op         = min_erp_pkg::OP_ADD;
                    n_edge_cnt = r_edge_cnt + 1'b1;
                end
            end
            min_erp_pkg::CMD_QUERY: begin
                if (!out_of_range) begin
                    op = min_erp_pkg::OP_QUERY;
                end
            end
            min_erp_pkg::CMD_CLEAR: begin
                op         = min_erp_pkg::OP_CLEAR;
                n_edge_cnt = '0;
            end
            default: begin
                op = min_erp_pkg::OP_REJECT;
            end
        endcase
    end

    // Add carries its store slot, query carries the edge count.
    assign o_job = {op, i_first_node, i_second_node, r_edge_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt <= '0;
        end else if (i_accept) begin
            r_edge_cnt <= n_edge_cnt;
        end
    end
endmodule

>>> rtl/min_erp_back.sv
// Back end: edge store, distance store and the 0-1 relaxation search.
module min_erp_back #(
    parameter int MAX_EDGES = 1024,
    parameter int EW        = 11
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [min_erp_pkg::NODE_W-1:0]       i_top,
    input  logic                                 i_job_valid,
    input  logic [2+2*min_erp_pkg::NODE_W+EW-1:0] i_job,
    output logic                                 o_job_pop,
    input  logic                                 i_res_full,
    output logic                                 o_res_push,
    output logic [min_erp_pkg::RES_W-1:0]        o_res_data
);
    localparam int NW = min_erp_pkg::NODE_W;
    localparam int DW = min_erp_pkg::DIST_W;
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int JW = 2 + 2*NW + EW;

    min_erp_pkg::t_op     j_op;
    logic [NW-1:0]        j_a, j_b;
    logic [EW-1:0]        j_cnt;

    assign j_op  = min_erp_pkg::t_op'(i_job[JW-1 -: 2]);
    assign j_a   = i_job[EW+2*NW-1 -: NW];
    assign j_b   = i_job[EW+NW-1 -: NW];
    assign j_cnt = i_job[EW-1:0];

    min_erp_pkg::t_bstate r_state, n_state;

    logic [NW-1:0] r_tail_mem [MAX_EDGES];
    logic [NW-1:0] r_head_mem [MAX_EDGES];
    logic [DW-1:0] r_dist_mem [min_erp_pkg::MAX_NODES];

    logic [NW-1:0] r_src, r_dst, r_sweep;
    logic [EW-1:0] r_cnt, r_idx;
    logic          r_changed;
    logic [NW-1:0] r_tail_q, r_head_q;
    logic [DW-1:0] r_du, r_dv;

    // control outputs
    logic          edge_we;
    logic          dist_we;
    logic [NW-1:0] dist_waddr;
    logic [DW-1:0] dist_wdata;
    logic [NW-1:0] dist_raddr_a;

    // relaxation of the current edge
    logic          stale, fwd, bwd, upd, last;
    logic [NW:0]   back_cand;

    assign stale     = (r_tail_q > i_top) || (r_head_q > i_top);
    assign back_cand = {1'b0, r_dv[NW-1:0]} + 1'b1;
    assign fwd = !stale && r_du[NW] && (!r_dv[NW] || (r_du[NW-1:0] < r_dv[NW-1:0]));
    assign bwd = !stale && !fwd && r_dv[NW] &&
                 (!r_du[NW] || (back_cand < {1'b0, r_du[NW-1:0]}));
    assign upd  = fwd || bwd;
    assign last = ((r_idx + 1'b1) == r_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            min_erp_pkg::BS_IDLE: begin
                if (i_job_valid && (j_op == min_erp_pkg::OP_QUERY)) begin
                    n_state = min_erp_pkg::BS_INIT;
                end
            end
            min_erp_pkg::BS_INIT: begin
                if (r_sweep == NW'(min_erp_pkg::MAX_NODES - 1)) begin
                    n_state = min_erp_pkg::BS_PASS;
                end
            end
            min_erp_pkg::BS_PASS: begin
                n_state = (r_cnt == '0) ? min_erp_pkg::BS_FIN_RD : min_erp_pkg::BS_EDGE_RD;
            end
            min_erp_pkg::BS_EDGE_RD: n_state = min_erp_pkg::BS_DIST_RD;
            min_erp_pkg::BS_DIST_RD: n_state = min_erp_pkg::BS_RELAX;
            min_erp_pkg::BS_RELAX: begin
                priority if (!last) begin
                    n_state = min_erp_pkg::BS_EDGE_RD;
                end else if (r_changed || upd) begin
                    n_state = min_erp_pkg::BS_PASS;
                end else begin
                    n_state = min_erp_pkg::BS_FIN_RD;
                end
            end
            min_erp_pkg::BS_FIN_RD: n_state = min_erp_pkg::BS_FIN;
            min_erp_pkg::BS_FIN: begin
                if (!i_res_full) begin
                    n_state = min_erp_pkg::BS_IDLE;
                end
            end
            default: n_state = min_erp_pkg::BS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_job_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res_data   = '0;
        edge_we      = 1'b0;
        dist_we      = 1'b0;
        dist_waddr   = r_sweep;
        dist_wdata   = '0;
        dist_raddr_a = r_tail_q;
        unique case (r_state)
            min_erp_pkg::BS_IDLE: begin
                if (i_job_valid) begin
                    if (j_op == min_erp_pkg::OP_QUERY) begin
                        o_job_pop = 1'b1;
                    end else if (!i_res_full) begin
                        o_job_pop  = 1'b1;
                        o_res_push = 1'b1;
                        o_res_data = {(j_op != min_erp_pkg::OP_REJECT), NW'(0)};
                        edge_we    = (j_op == min_erp_pkg::OP_ADD);
                    end
                end
            end
            min_erp_pkg::BS_INIT: begin
                dist_we    = 1'b1;
                dist_waddr = r_sweep;
                dist_wdata = {(r_sweep == r_src), NW'(0)};
            end
            min_erp_pkg::BS_RELAX: begin
                dist_we    = upd;
                dist_waddr = fwd ? r_head_q : r_tail_q;
                dist_wdata = fwd ? {1'b1, r_du[NW-1:0]} : {1'b1, back_cand[NW-1:0]};
            end
            min_erp_pkg::BS_FIN_RD: begin
                dist_raddr_a = r_dst;
            end
            min_erp_pkg::BS_FIN: begin
                dist_raddr_a = r_dst;
                o_res_push   = !i_res_full;
                o_res_data   = {r_du[NW], r_du[NW] ? r_du[NW-1:0] : NW'(0)};
            end
            default: begin
                o_job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= min_erp_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // search bookkeeping
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            min_erp_pkg::BS_IDLE: begin
                r_src   <= j_a;
                r_dst   <= j_b;
                r_cnt   <= j_cnt;
                r_sweep <= '0;
            end
            min_erp_pkg::BS_INIT: r_sweep <= r_sweep + 1'b1;
            min_erp_pkg::BS_PASS: begin
                r_idx     <= '0;
                r_changed <= 1'b0;
            end
            min_erp_pkg::BS_RELAX: begin
                r_idx     <= r_idx + 1'b1;
                r_changed <= r_changed || upd;
            end
            default: r_idx <= r_idx;
        endcase
    end

    // edge store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_tail_mem[j_cnt[AW-1:0]] <= j_a;
            r_head_mem[j_cnt[AW-1:0]] <= j_b;
        end
        r_tail_q <= r_tail_mem[r_idx[AW-1:0]];
        r_head_q <= r_head_mem[r_idx[AW-1:0]];
    end

    // distance store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[dist_waddr] <= dist_wdata;
        end
        r_du <= r_dist_mem[dist_raddr_a];
        r_dv <= r_dist_mem[r_head_q];
    end
endmodule

>>> rtl/min_edge_reversal_path_core.sv
// Top level of the minimum edge reversal path block.
// Usage:
//   Input queue: drive i_command/i_first_node/i_second_node with push; a word
//   is taken when push is high and full is low. Commands: add edge, run
//   query, clear edge store. Result queue: ok/reversals are valid while
//   empty is low; pop takes the word. One result word per input word,
//   in order.
//   Config: i_cfg_we writes i_cfg_wdata into highest_node (reset 255);
//   write only while the block is idle.
// Operation:
//   Add, clear and rejected words go through one per cycle while the
//   result queue has room and no query runs; each result passes the job
//   queue and the result queue before it is visible.
//   A query sweeps the distance store, then runs relaxation passes over
//   the edge store until a pass changes nothing; a pass starts in
//   BS_PASS and steps each edge through BS_EDGE_RD, BS_DIST_RD, BS_RELAX.
// Reset clears the queues, the edge count and the back-end state machine;
// stored edges are forgotten by the count alone. A stalled receiver fills
// the result queue, then the job queue, then raises full.
module min_edge_reversal_path_core #(
    parameter int MAX_EDGES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     i_command,
    input  logic [min_erp_pkg::NODE_W-1:0] i_first_node,
    input  logic [min_erp_pkg::NODE_W-1:0] i_second_node,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_ok,
    output logic [min_erp_pkg::NODE_W-1:0] o_reversals,
    input  logic                           i_cfg_we,
    input  logic [min_erp_pkg::NODE_W-1:0] i_cfg_wdata
);
    localparam int NW = min_erp_pkg::NODE_W;
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int JW = 2 + 2*NW + EW;

    logic [NW-1:0] r_highest_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest_node <= '1;
        end else if (i_cfg_we) begin
            r_highest_node <= i_cfg_wdata;
        end
    end

    logic [JW-1:0] front_job, queued_job;
    logic          accept, job_empty, job_pop;
    logic          res_push, res_full;
    logic [min_erp_pkg::RES_W-1:0] res_data, res_out;

    assign accept = push && !full;

    min_erp_front #(.MAX_EDGES(MAX_EDGES), .EW(EW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_first_node (i_first_node),
        .i_second_node(i_second_node),
        .i_top        (r_highest_node),
        .o_job        (front_job)
    );

    // decouples classification from execution
    min_erp_fifo #(.W(JW), .DEPTH(4)) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_job),
        .o_full (full),
        .i_pop  (job_pop),
        .o_data (queued_job),
        .o_empty(job_empty)
    );

    min_erp_back #(.MAX_EDGES(MAX_EDGES), .EW(EW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_top      (r_highest_node),
        .i_job_valid(!job_empty),
        .i_job      (queued_job),
        .o_job_pop  (job_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res_data (res_data)
    );

    // result words wait here for the receiver
    min_erp_fifo #(.W(min_erp_pkg::RES_W), .DEPTH(2)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_data),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_out),
        .o_empty(empty)
    );

    assign o_ok        = res_out[NW];
    assign o_reversals = res_out[NW-1:0];
endmodule

>>> rtl/min_erp_checker.sv
// Port-level checks for the minimum edge reversal path block, with bind.
`include "min_edge_reversal_path_core_defines.svh"

module min_erp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic                           o_ok,
    input logic [min_erp_pkg::NODE_W-1:0] o_reversals
);
    `MERP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, empty, "result queue not empty after reset")
    `MERP_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_ok) && $stable(o_reversals), "waiting result changed")
    `MERP_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, !empty && !o_ok, o_reversals == '0, "failed result carries reversals")
endmodule

bind min_edge_reversal_path_core min_erp_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_ok       (o_ok),
    .o_reversals(o_reversals)
);
